@@ rtl/core/pft_pkg.sv @@
package pft_pkg;

  // Operation codes carried in the op field
  localparam logic [1:0] OP_ASSIGN  = 2'd0;
  localparam logic [1:0] OP_EVICT   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_LOOKUP  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // latch the incoming item
    logic clr_wr;       // clearing write after reset
    logic set_range;    // report frame out of range
    logic set_empty;    // report empty queue on evict
    logic asg;          // record owner and append to ring
    logic pop;          // pop ring head
    logic ev_rd;        // read frame entry of the victim
    logic ev_wr;        // free the victim
    logic lk_rd;        // read frame entry for lookup
    logic lk_dat;       // capture lookup owner
    logic scan_init;    // start free search above the assigned frame
    logic scan;         // free search step
    logic rel1_init;    // start release sweep over frames
    logic rel1;         // release sweep step
    logic rel2_init;    // start ring compaction
    logic rel2;         // compaction step
    logic rel2_commit;  // swap ring banks and load pointers
    logic head_rd;      // read ring head
    logic head_wt;      // capture ring head
    logic out_load;     // load result register
  } pft_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       frame_bad;
    logic       ring_empty;
    logic       scan_trig;
    logic       clr_last;
    logic       scan_done;
    logic       rel1_done;
    logic       rel2_done;
  } pft_sts_t;

endpackage

@@ rtl/core/pft_ram.sv @@
module pft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/pft_ctrl.sv @@
module pft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output pft_pkg::pft_cmd_t cmd,
  input  pft_pkg::pft_sts_t sts
);
  import pft_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_EV_RD    = 4'd3;
  localparam logic [3:0] S_EV_WR    = 4'd4;
  localparam logic [3:0] S_LK_RD    = 4'd5;
  localparam logic [3:0] S_LK_DAT   = 4'd6;
  localparam logic [3:0] S_REL1     = 4'd7;
  localparam logic [3:0] S_REL2     = 4'd8;
  localparam logic [3:0] S_SCAN     = 4'd9;
  localparam logic [3:0] S_HEAD_RD  = 4'd10;
  localparam logic [3:0] S_HEAD_WT  = 4'd11;
  localparam logic [3:0] S_FINISH   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  // Sequence one item through its steps
  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_ASSIGN: begin
            if (sts.frame_bad) begin
              cmd.set_range = 1'b1;
              state_next    = S_FINISH;
            end else if (sts.scan_trig) begin
              cmd.asg       = 1'b1;
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end else begin
              cmd.asg    = 1'b1;
              state_next = S_HEAD_RD;
            end
          end
          OP_EVICT: begin
            if (sts.ring_empty) begin
              cmd.set_empty = 1'b1;
              state_next    = S_FINISH;
            end else begin
              cmd.pop    = 1'b1;
              state_next = S_EV_RD;
            end
          end
          OP_RELEASE: begin
            cmd.rel1_init = 1'b1;
            state_next    = S_REL1;
          end
          OP_LOOKUP: begin
            if (sts.frame_bad) begin
              cmd.set_range = 1'b1;
              state_next    = S_FINISH;
            end else begin
              state_next = S_LK_RD;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_EV_RD: begin
        cmd.ev_rd  = 1'b1;
        state_next = S_EV_WR;
      end
      S_EV_WR: begin
        cmd.ev_wr  = 1'b1;
        state_next = S_HEAD_RD;
      end
      S_LK_RD: begin
        cmd.lk_rd  = 1'b1;
        state_next = S_LK_DAT;
      end
      S_LK_DAT: begin
        cmd.lk_dat = 1'b1;
        state_next = S_FINISH;
      end
      S_REL1: begin
        if (sts.rel1_done) begin
          cmd.rel2_init = 1'b1;
          state_next    = S_REL2;
        end else begin
          cmd.rel1 = 1'b1;
        end
      end
      S_REL2: begin
        if (sts.rel2_done) begin
          cmd.rel2_commit = 1'b1;
          state_next      = S_HEAD_RD;
        end else begin
          cmd.rel2 = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_HEAD_RD;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_next  = S_HEAD_WT;
      end
      S_HEAD_WT: begin
        cmd.head_wt = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!m_tvalid && !s_tready))
    else $error("channel active during clearing pass");

endmodule

@@ rtl/core/pft_dp.sv @@
module pft_dp #(
  parameter int NUM_FRAMES = 64,
  parameter int PROC_BITS  = 8,
  parameter int PAGE_BITS  = 10,
  localparam int FW     = $clog2(NUM_FRAMES),
  localparam int CW     = $clog2(NUM_FRAMES + 1),
  localparam int IN_W   = 2 + FW + PROC_BITS + PAGE_BITS,
  localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = 2 + FW + 1 + PROC_BITS + PAGE_BITS + 1 + FW + 1 + FW + CW,
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_DW-1:0]  s_tdata,
  output logic [OUT_DW-1:0] m_tdata,
  input  pft_pkg::pft_cmd_t cmd,
  output pft_pkg::pft_sts_t sts
);
  import pft_pkg::*;

  localparam int PB  = PROC_BITS;
  localparam int GB  = PAGE_BITS;
  localparam int EW  = 1 + PB + GB;
  localparam int RAW = FW + 1;
  localparam logic [CW-1:0] N_CW  = CW'(NUM_FRAMES);
  localparam logic [CW-1:0] N_M1  = CW'(NUM_FRAMES - 1);
  localparam logic [FW-1:0] LAST  = FW'(NUM_FRAMES - 1);

  function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] x);
    return (x == LAST) ? '0 : x + 1'b1;
  endfunction

  // Latched item and result fields
  logic [1:0]    op_q;
  logic [FW-1:0] frame_q;
  logic [PB-1:0] proc_q;
  logic [GB-1:0] page_q;
  logic [1:0]    status_q;
  logic [FW-1:0] rframe;
  logic          ovalid;
  logic [PB-1:0] oproc;
  logic [GB-1:0] opage;

  // Ring pointers, free search and sweep state
  logic [FW-1:0] head;
  logic [FW-1:0] tail;
  logic [FW-1:0] walk;
  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [CW-1:0] sw_idx;
  logic          bank;
  logic          found;
  logic [FW-1:0] ff;
  logic [FW-1:0] nv;
  logic          p1_vld;
  logic [FW-1:0] p1_idx;
  logic          p2_vld;
  logic [FW-1:0] p2_q;

  // Frame table memory: {free, proc, page}
  logic           f_we;
  logic [FW-1:0]  f_waddr;
  logic [EW-1:0]  f_wdata;
  logic [FW-1:0]  f_raddr;
  logic [EW-1:0]  f_rdata;
  logic           rd_free;
  logic [PB-1:0]  rd_proc;
  logic [GB-1:0]  rd_page;

  // Ring memory, two banks of one ring each
  logic           r_we;
  logic [RAW-1:0] r_waddr;
  logic [FW-1:0]  r_wdata;
  logic [RAW-1:0] r_raddr;
  logic [FW-1:0]  r_rdata;

  logic          issue;
  logic [CW-1:0] sweep_lim;
  logic          rel1_match;
  logic          now_free;
  logic          keep;
  logic [OUT_W-1:0] out_word;

  pft_ram #(.WIDTH(EW), .DEPTH(NUM_FRAMES)) u_frame_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  pft_ram #(.WIDTH(FW), .DEPTH(2 ** RAW)) u_ring_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  assign rd_free = f_rdata[EW-1];
  assign rd_proc = f_rdata[GB +: PB];
  assign rd_page = f_rdata[GB-1:0];

  // Sweep issue and per-entry decisions
  assign sweep_lim  = cmd.rel2 ? count : N_CW;
  assign issue      = (cmd.scan || cmd.rel1 || cmd.rel2) && (sw_idx < sweep_lim);
  assign rel1_match = p1_vld && !rd_free && (rd_proc == proc_q);
  assign now_free   = rd_free || rel1_match;
  assign keep       = cmd.rel2 && p2_vld && !rd_free;

  // Frame table write port
  always_comb begin
    f_we    = 1'b0;
    f_waddr = frame_q;
    f_wdata = {1'b1, rd_proc, rd_page};
    priority if (cmd.clr_wr) begin
      f_we    = 1'b1;
      f_waddr = sw_idx[FW-1:0];
      f_wdata = {1'b1, {(PB + GB){1'b0}}};
    end else if (cmd.asg) begin
      f_we    = 1'b1;
      f_wdata = {1'b0, proc_q, page_q};
    end else if (cmd.ev_wr) begin
      f_we    = 1'b1;
      f_waddr = rframe;
    end else if (cmd.rel1 && rel1_match) begin
      f_we    = 1'b1;
      f_waddr = p1_idx;
    end else begin
      f_we = 1'b0;
    end
  end

  // Frame table read address
  always_comb begin
    priority if (cmd.ev_rd) begin
      f_raddr = rframe;
    end else if (cmd.lk_rd) begin
      f_raddr = frame_q;
    end else if (cmd.rel2) begin
      f_raddr = r_rdata;
    end else begin
      f_raddr = sw_idx[FW-1:0];
    end
  end

  // Ring ports: append on assign, gather survivors into the other bank
  always_comb begin
    r_we    = 1'b0;
    r_waddr = {bank, tail};
    r_wdata = frame_q;
    if (cmd.asg) begin
      r_we = 1'b1;
    end else if (keep) begin
      r_we    = 1'b1;
      r_waddr = {~bank, n[FW-1:0]};
      r_wdata = p2_q;
    end
    r_raddr = cmd.head_rd ? {bank, head} : {bank, walk};
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      walk   <= '0;
      count  <= '0;
      n      <= '0;
      sw_idx <= '0;
      bank   <= 1'b0;
      found  <= 1'b1;
      ff     <= '0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        sw_idx <= sw_idx + 1'b1;
      end
      if (cmd.asg) begin
        tail <= wrap_inc(tail);
        if (count != N_CW) begin
          count <= count + 1'b1;
        end else begin
          head <= wrap_inc(tail);
        end
      end
      if (cmd.pop) begin
        head  <= wrap_inc(head);
        count <= count - 1'b1;
      end
      // Freed victim may become the lowest free frame
      if (cmd.ev_wr && (!found || (rframe < ff))) begin
        found <= 1'b1;
        ff    <= rframe;
      end
      if (cmd.scan_init) begin
        sw_idx <= CW'(frame_q) + 1'b1;
        found  <= 1'b0;
      end
      if (cmd.rel1_init) begin
        sw_idx <= '0;
        found  <= 1'b0;
      end
      if (cmd.rel2_init) begin
        sw_idx <= '0;
        walk   <= head;
        n      <= '0;
      end
      if (issue) begin
        sw_idx <= sw_idx + 1'b1;
        if (cmd.rel2) begin
          walk <= wrap_inc(walk);
        end
      end
      // Record the first free frame seen by a sweep
      if (((cmd.scan && rd_free) || (cmd.rel1 && now_free)) && p1_vld && !found) begin
        found <= 1'b1;
        ff    <= p1_idx;
      end
      if (keep) begin
        n <= n + 1'b1;
      end
      if (cmd.rel2_commit) begin
        bank  <= ~bank;
        head  <= '0;
        tail  <= (n == N_CW) ? '0 : n[FW-1:0];
        count <= n;
      end
      p1_vld <= issue;
      p2_vld <= cmd.rel2 && p1_vld;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p1_idx <= sw_idx[FW-1:0];
    p2_q   <= r_rdata;
    if (cmd.load) begin
      op_q     <= s_tdata[1:0];
      frame_q  <= s_tdata[2 +: FW];
      proc_q   <= s_tdata[2 + FW +: PB];
      page_q   <= s_tdata[2 + FW + PB +: GB];
      status_q <= ST_OK;
      rframe   <= s_tdata[2 +: FW];
      ovalid   <= 1'b0;
      oproc    <= '0;
      opage    <= '0;
    end
    if (cmd.set_range) begin
      status_q <= ST_RANGE;
    end
    if (cmd.set_empty) begin
      status_q <= ST_EMPTY;
      rframe   <= '0;
    end
    if (cmd.pop) begin
      rframe <= nv;
    end
    if (cmd.ev_wr && !rd_free) begin
      oproc <= rd_proc;
      opage <= rd_page;
    end
    if (cmd.lk_dat && !rd_free) begin
      ovalid <= 1'b1;
      oproc  <= rd_proc;
      opage  <= rd_page;
    end
    if (cmd.head_wt) begin
      nv <= r_rdata;
    end
    if (cmd.out_load) begin
      m_tdata <= OUT_DW'(out_word);
    end
  end

  // Result word, highest field first
  assign out_word = {count,
                     (count != '0) ? nv : {FW{1'b0}},
                     (count != '0),
                     found ? ff : {FW{1'b0}},
                     found,
                     opage, oproc, ovalid, rframe, status_q};

  // Status to the controller
  assign sts.op         = op_q;
  assign sts.frame_bad  = (CW'(frame_q) >= N_CW);
  assign sts.ring_empty = (count == '0);
  assign sts.scan_trig  = found && (frame_q == ff);
  assign sts.clr_last   = (sw_idx == N_M1);
  assign sts.scan_done  = found || ((sw_idx >= N_CW) && !p1_vld);
  assign sts.rel1_done  = (sw_idx >= N_CW) && !p1_vld;
  assign sts.rel2_done  = (sw_idx >= count) && !p1_vld && !p2_vld;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= N_CW)
    else $error("ring count above frame count");

  a_assign_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.asg |-> !sts.frame_bad)
    else $error("ring append of an out-of-range frame");

  a_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.rel2_commit |=> ((head == '0) && (count == $past(n))))
    else $error("compaction commit lost the survivor count");

endmodule

@@ rtl/core/page_frame_table_fifo.sv @@
// Channel  Dir  Fields (low bit first)
// s_*      in   op, frame, proc_id, page_num
// m_*      out  status, result_frame, owner_valid, owner_proc, owner_page,
//               free_found, first_free, victim_found, next_victim, queue_count
//
// After reset a clearing pass marks every frame free; s_tready stays low
// until it ends. One item at a time; the frame table RAM has one read
// port, so sweeps go one frame per cycle. Assign searches the frame table
// above the assigned frame for the next free one when it takes the lowest
// free frame. Release makes one sweep over the frame table, then one over
// the ring entries. A new item is taken while a result waits in the
// output register; the next result waits until that one is taken.
module page_frame_table_fifo #(
  parameter int NUM_FRAMES = 64,
  parameter int PROC_BITS  = 8,
  parameter int PAGE_BITS  = 10,
  localparam int FW     = $clog2(NUM_FRAMES),
  localparam int CW     = $clog2(NUM_FRAMES + 1),
  localparam int IN_W   = 2 + FW + PROC_BITS + PAGE_BITS,
  localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = 2 + FW + 1 + PROC_BITS + PAGE_BITS + 1 + FW + 1 + FW + CW,
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // op, frame, proc_id, page_num
  input  logic [IN_DW-1:0]  s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // status, result_frame, owner_valid, owner_proc, owner_page, free_found,
  // first_free, victim_found, next_victim, queue_count
  output logic [OUT_DW-1:0] m_tdata
);
  import pft_pkg::*;

  pft_cmd_t cmd;
  pft_sts_t sts;

  pft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pft_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .PROC_BITS  (PROC_BITS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule
